### hw/rtl/md5sh_pkg.sv
// Package for the MD5 stream hasher: word group type, sequencer states,
// the initial chaining values, and the per-round constant, rotation and index functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package md5sh_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5sh_words_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_DIGEST
  } md5sh_state_t;

  localparam md5sh_words_t MD5SH_INIT = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476
  };

  localparam logic [7:0] MD5SH_PAD_MARK = 8'h80;

  function automatic logic [31:0] md5sh_round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'd3614090360;
      6'd1:  k = 32'd3905402710;
      6'd2:  k = 32'd606105819;
      6'd3:  k = 32'd3250441966;
      6'd4:  k = 32'd4118548399;
      6'd5:  k = 32'd1200080426;
      6'd6:  k = 32'd2821735955;
      6'd7:  k = 32'd4249261313;
      6'd8:  k = 32'd1770035416;
      6'd9:  k = 32'd2336552879;
      6'd10: k = 32'd4294925233;
      6'd11: k = 32'd2304563134;
      6'd12: k = 32'd1804603682;
      6'd13: k = 32'd4254626195;
      6'd14: k = 32'd2792965006;
      6'd15: k = 32'd1236535329;
      6'd16: k = 32'd4129170786;
      6'd17: k = 32'd3225465664;
      6'd18: k = 32'd643717713;
      6'd19: k = 32'd3921069994;
      6'd20: k = 32'd3593408605;
      6'd21: k = 32'd38016083;
      6'd22: k = 32'd3634488961;
      6'd23: k = 32'd3889429448;
      6'd24: k = 32'd568446438;
      6'd25: k = 32'd3275163606;
      6'd26: k = 32'd4107603335;
      6'd27: k = 32'd1163531501;
      6'd28: k = 32'd2850285829;
      6'd29: k = 32'd4243563512;
      6'd30: k = 32'd1735328473;
      6'd31: k = 32'd2368359562;
      6'd32: k = 32'd4294588738;
      6'd33: k = 32'd2272392833;
      6'd34: k = 32'd1839030562;
      6'd35: k = 32'd4259657740;
      6'd36: k = 32'd2763975236;
      6'd37: k = 32'd1272893353;
      6'd38: k = 32'd4139469664;
      6'd39: k = 32'd3200236656;
      6'd40: k = 32'd681279174;
      6'd41: k = 32'd3936430074;
      6'd42: k = 32'd3572445317;
      6'd43: k = 32'd76029189;
      6'd44: k = 32'd3654602809;
      6'd45: k = 32'd3873151461;
      6'd46: k = 32'd530742520;
      6'd47: k = 32'd3299628645;
      6'd48: k = 32'd4096336452;
      6'd49: k = 32'd1126891415;
      6'd50: k = 32'd2878612391;
      6'd51: k = 32'd4237533241;
      6'd52: k = 32'd1700485571;
      6'd53: k = 32'd2399980690;
      6'd54: k = 32'd4293915773;
      6'd55: k = 32'd2240044497;
      6'd56: k = 32'd1873313359;
      6'd57: k = 32'd4264355552;
      6'd58: k = 32'd2734768916;
      6'd59: k = 32'd1309151649;
      6'd60: k = 32'd4149444226;
      6'd61: k = 32'd3174756917;
      6'd62: k = 32'd718787259;
      default: k = 32'd3951481745;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5sh_rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'hA: s = 5'd16;
      4'hB: s = 5'd23;
      4'hC: s = 5'd6;
      4'hD: s = 5'd10;
      4'hE: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5sh_msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
      2'd2: g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
      default: g = 4'((r[3:0] << 3) - r[3:0]);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/md5sh_round.sv
// One MD5 round step: mixing function, four-operand add, rotation and final add.
// Depends on md5sh_pkg for the word group type and the round tables.
`timescale 1ns / 1ps
`default_nettype none

module md5sh_round (
  input  md5sh_pkg::md5sh_words_t words_in,
  input  logic [31:0]             msg_word,
  input  logic [5:0]              round_idx,
  output md5sh_pkg::md5sh_words_t words_out
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] rot_wide;

  always_comb begin
    case (round_idx[5:4])
      2'd0: f = (words_in.b & words_in.c) | (~words_in.b & words_in.d);
      2'd1: f = (words_in.d & words_in.b) | (~words_in.d & words_in.c);
      2'd2: f = words_in.b ^ words_in.c ^ words_in.d;
      default: f = words_in.c ^ (words_in.b | ~words_in.d);
    endcase
    sum = words_in.a + f + md5sh_pkg::md5sh_round_const(round_idx) + msg_word;
    s = md5sh_pkg::md5sh_rot_amount(round_idx);
    rot_wide = {sum, sum} << s;
    words_out.a = words_in.d;
    words_out.b = words_in.b + rot_wide[63:32];
    words_out.c = words_in.b;
    words_out.d = words_in.c;
  end

endmodule

`default_nettype wire

### hw/rtl/md5_stream_hasher_top.sv
// Top level of the MD5 stream hasher: byte packing, padding sequencer and round loop.
// Depends on md5sh_pkg and md5sh_round.
`timescale 1ns / 1ps
`default_nettype none

// A message enters one byte per transaction and one 128-bit digest leaves per message.
// A byte that does not complete a 64-byte block leaves the sequencer in ST_IDLE. The byte that
// completes a block starts a compression: the single shared round unit runs every round
// in ST_ROUND, then ST_FOLD adds into the chaining words, with in_ready low throughout. On the
// end-of-message transaction the padding is written one byte per cycle (9 to 72 byte
// writes across one or two blocks), each full block is compressed as above, and
// ST_DIGEST loads the digest; in_ready stays low from the end transaction until it is
// loaded, longer while the previous digest has not been taken. The digest is held
// in an output register until taken; bytes of the next message are accepted meanwhile.
module md5_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_low,
  output logic [63:0] digest_high
);

  md5sh_pkg::md5sh_state_t state, state_next;
  md5sh_pkg::md5sh_words_t chain, work, round_out;

  logic [31:0] block_words [16];
  logic [5:0]  fill;
  logic [63:0] message_bytes;
  logic [5:0]  round;
  logic        in_pad;
  logic        pad_first;
  logic        pad_len;
  logic        final_blk;

  logic        accept;
  logic        put_en;
  logic [7:0]  put_val;
  logic        put_full;
  logic [63:0] len_bits;
  logic        digest_load;

  assign accept   = in_valid && in_ready;
  assign len_bits = {message_bytes[60:0], 3'b000};
  assign put_full = put_en && (fill == 6'd63);

  md5sh_round u_round (
    .words_in  (work),
    .msg_word  (block_words[md5sh_pkg::md5sh_msg_index(round)]),
    .round_idx (round),
    .words_out (round_out)
  );

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    put_en      = 1'b0;
    put_val     = data_byte;
    digest_load = 1'b0;
    case (state)
      md5sh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          put_en = byte_present;
          if (byte_present && (fill == 6'd63)) begin
            state_next = md5sh_pkg::ST_ROUND;
          end else if (end_of_message) begin
            state_next = md5sh_pkg::ST_PAD;
          end
        end
      end
      md5sh_pkg::ST_PAD: begin
        put_en = 1'b1;
        if (pad_first) begin
          put_val = md5sh_pkg::MD5SH_PAD_MARK;
        end else if (pad_len) begin
          put_val = len_bits[{fill[2:0], 3'b000} +: 8];
        end else begin
          put_val = 8'h00;
        end
        if (fill == 6'd63) begin
          state_next = md5sh_pkg::ST_ROUND;
        end
      end
      md5sh_pkg::ST_ROUND: begin
        if (round == 6'd63) begin
          state_next = md5sh_pkg::ST_FOLD;
        end
      end
      md5sh_pkg::ST_FOLD: begin
        if (final_blk) begin
          state_next = md5sh_pkg::ST_DIGEST;
        end else if (in_pad) begin
          state_next = md5sh_pkg::ST_PAD;
        end else begin
          state_next = md5sh_pkg::ST_IDLE;
        end
      end
      md5sh_pkg::ST_DIGEST: begin
        if (!out_valid || out_ready) begin
          digest_load = 1'b1;
          state_next  = md5sh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = md5sh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5sh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      block_words[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= put_val;
    end
  end

  always_ff @(posedge clk) begin
    if (put_full) begin
      work <= chain;
    end else if (state == md5sh_pkg::ST_ROUND) begin
      work <= round_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain         <= md5sh_pkg::MD5SH_INIT;
      fill          <= '0;
      message_bytes <= '0;
      round         <= '0;
      in_pad        <= 1'b0;
      pad_first     <= 1'b0;
      pad_len       <= 1'b0;
      final_blk     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      if (accept && byte_present) begin
        message_bytes <= message_bytes + 64'd1;
      end
      if (accept && end_of_message) begin
        in_pad    <= 1'b1;
        pad_first <= 1'b1;
      end
      if (state == md5sh_pkg::ST_PAD) begin
        pad_first <= 1'b0;
        if (fill == 6'd55) begin
          pad_len <= 1'b1;
        end
        if ((fill == 6'd63) && pad_len) begin
          final_blk <= 1'b1;
        end
      end
      if (state == md5sh_pkg::ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == md5sh_pkg::ST_FOLD) begin
        chain.a <= chain.a + work.a;
        chain.b <= chain.b + work.b;
        chain.c <= chain.c + work.c;
        chain.d <= chain.d + work.d;
      end
      if (digest_load) begin
        chain         <= md5sh_pkg::MD5SH_INIT;
        fill          <= '0;
        message_bytes <= '0;
        in_pad        <= 1'b0;
        pad_len       <= 1'b0;
        final_blk     <= 1'b0;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (digest_load) begin
      digest_low  <= {chain.b, chain.a};
      digest_high <= {chain.d, chain.c};
    end
  end

endmodule

`default_nettype wire
